// ===== hw/rtl/mbe_pkg.sv =====
`timescale 1ns / 1ps
// shared widths, codes and word types of the escape-time pixel core
package mbe_pkg;

    localparam int POS_BITS      = 10;
    localparam int COLOR_BITS    = 24;
    localparam int LIMIT_BITS    = 8;
    localparam int COUNT_BITS    = LIMIT_BITS + 1;
    localparam int C_BITS        = 48;
    localparam int STEP_BITS     = 47;
    localparam int Z_BITS        = 64;
    localparam int FRAC_BITS     = 44;
    localparam int DIGIT_BITS    = 16;
    localparam int NUM_CELLS     = Z_BITS / DIGIT_BITS;
    localparam int KIND_BITS     = 2;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 48;

    localparam logic [CFG_IDX_BITS-1:0] CFG_LIMIT = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REAL  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAG  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STEP  = 3'd3;

    localparam logic [LIMIT_BITS-1:0] RST_LIMIT = 8'd50;
    localparam logic [C_BITS-1:0]     RST_REAL  = 48'hE000_0000_0000;
    localparam logic [C_BITS-1:0]     RST_IMAG  = 48'h2000_0000_0000;
    localparam logic [STEP_BITS-1:0]  RST_STEP  = 47'h0010_0000_0000;

    typedef struct packed {
        logic [POS_BITS-1:0] column;
        logic [POS_BITS-1:0] row;
        logic                row_end;
    } t_pixel_in;

    typedef struct packed {
        logic [POS_BITS-1:0]   out_column;
        logic [POS_BITS-1:0]   out_row;
        logic [COLOR_BITS-1:0] pixel_color;
        logic [COUNT_BITS-1:0] iteration_count;
    } t_pixel_out;

    typedef struct packed {
        logic [LIMIT_BITS-1:0] limit;
        logic [C_BITS-1:0]     real_origin;
        logic [C_BITS-1:0]     imag_origin;
        logic [STEP_BITS-1:0]  pixel_step;
    } t_view_cfg;

    // one product in flight along the multiplier chain
    typedef struct packed {
        logic                 valid;
        logic [KIND_BITS-1:0] kind;
        logic                 neg;
        logic [Z_BITS-1:0]    a;
        logic [Z_BITS-1:0]    b;
        logic [Z_BITS-1:0]    hi;
        logic [Z_BITS-1:0]    lo;
    } t_cell_bus;

    typedef struct packed {
        logic start;
        logic ack;
    } t_iter_ctrl;

    typedef struct packed {
        logic                  done;
        logic [COUNT_BITS-1:0] count;
    } t_iter_status;

endpackage

// ===== hw/rtl/mandelbrot_escape_time_pixel_core.sv =====
`timescale 1ns / 1ps
// top level of the escape-time pixel core: handshakes, view registers, result word
//
// Colors one pixel at a time. A pixel word is taken, mapped to c in the Q4.44
// view set by the configuration registers, and iterated until it escapes or
// the iteration limit is reached; its result word then goes to the output
// register, and the next pixel word is taken on the following cycle even if
// that result is still stalled. Each iteration streams its three 64-bit
// products through the four-cell multiplier chain and needs all of them
// before the next one can start; a pixel that never escapes runs every
// iteration up to the limit, which is 50 at reset. Configuration writes are
// always ready and take effect at once; an index beyond the four registers
// is ignored.
module mandelbrot_escape_time_pixel_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  mbe_pkg::t_pixel_in                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output mbe_pkg::t_pixel_out               o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mbe_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [mbe_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import mbe_pkg::*;

    t_view_cfg             r_cfg, n_cfg;
    t_pixel_in             r_pix;
    logic                  r_busy;
    logic                  r_out_valid;
    t_pixel_out            r_out_data;
    logic                  w_accept;
    logic                  w_ack;
    t_iter_ctrl            w_ctrl;
    t_iter_status          w_status;
    logic [COLOR_BITS-1:0] w_color;

    assign w_accept    = i_in_valid && !r_busy;
    // result word moves to the output register once that register is free
    assign w_ack       = w_status.done && (!r_out_valid || !i_out_stall);
    assign w_ctrl.start = w_accept;
    assign w_ctrl.ack   = w_ack;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LIMIT: n_cfg.limit       = i_cfg_data[LIMIT_BITS-1:0];
                CFG_REAL:  n_cfg.real_origin = i_cfg_data[C_BITS-1:0];
                CFG_IMAG:  n_cfg.imag_origin = i_cfg_data[C_BITS-1:0];
                CFG_STEP:  n_cfg.pixel_step  = i_cfg_data[STEP_BITS-1:0];
                default: ;
            endcase
        end
    end

    mbe_iter u_iter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl),
        .i_cfg    (r_cfg),
        .i_column (r_pix.column),
        .i_row    (r_pix.row),
        .o_status (w_status)
    );

    mbe_color u_color (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_commit  (w_ack),
        .i_row_end (r_pix.row_end),
        .i_count   (w_status.count),
        .i_limit   (r_cfg.limit),
        .o_color   (w_color)
    );

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pix <= i_in_data;
        end
        if (w_ack) begin
            r_out_data.out_column      <= r_pix.column;
            r_out_data.out_row         <= r_pix.row;
            r_out_data.pixel_color     <= w_color;
            r_out_data.iteration_count <= w_status.count;
        end
        if (!i_rst_n) begin
            r_cfg.limit       <= RST_LIMIT;
            r_cfg.real_origin <= RST_REAL;
            r_cfg.imag_origin <= RST_IMAG;
            r_cfg.pixel_step  <= RST_STEP;
            r_busy            <= 1'b0;
            r_out_valid       <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_ack) begin
                r_busy <= 1'b0;
            end
            if (w_ack) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = r_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_cfg_ready = 1'b1;

endmodule

// ===== hw/rtl/mbe_cell.sv =====
`timescale 1ns / 1ps
// one digit cell of the multiplier chain: multiply-accumulate one multiplier digit
module mbe_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mbe_pkg::t_cell_bus i_bus,
    output mbe_pkg::t_cell_bus o_bus
);
    import mbe_pkg::*;

    logic [Z_BITS+DIGIT_BITS-1:0] w_part;
    logic [Z_BITS+DIGIT_BITS-1:0] w_sum;
    t_cell_bus                    n_bus;
    t_cell_bus                    r_bus;

    assign w_part = {{DIGIT_BITS{1'b0}}, i_bus.a}
                  * {{Z_BITS{1'b0}}, i_bus.b[DIGIT_BITS-1:0]};
    assign w_sum  = {{DIGIT_BITS{1'b0}}, i_bus.hi} + w_part;

    always_comb begin
        n_bus    = i_bus;
        // low digit is final, shift it into the finished half
        n_bus.hi = w_sum[Z_BITS+DIGIT_BITS-1:DIGIT_BITS];
        n_bus.lo = {w_sum[DIGIT_BITS-1:0], i_bus.lo[Z_BITS-1:DIGIT_BITS]};
        n_bus.b  = {{DIGIT_BITS{1'b0}}, i_bus.b[Z_BITS-1:DIGIT_BITS]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus <= '0;
        end else begin
            r_bus <= n_bus;
        end
    end

    assign o_bus = r_bus;

endmodule

// ===== hw/rtl/mbe_iter.sv =====
`timescale 1ns / 1ps
// escape-time iterator: maps a pixel to c and runs z = z*z + c on the cell chain
module mbe_iter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mbe_pkg::t_iter_ctrl           i_ctrl,
    input  mbe_pkg::t_view_cfg            i_cfg,
    input  logic [mbe_pkg::POS_BITS-1:0]  i_column,
    input  logic [mbe_pkg::POS_BITS-1:0]  i_row,
    output mbe_pkg::t_iter_status         o_status
);
    import mbe_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MAP   = 3'd1;
    localparam logic [2:0] ST_SAT   = 3'd2;
    localparam logic [2:0] ST_ADD   = 3'd3;
    localparam logic [2:0] ST_MAG   = 3'd4;
    localparam logic [2:0] ST_ISSUE = 3'd5;
    localparam logic [2:0] ST_WAIT  = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    localparam logic [KIND_BITS-1:0] KIND_CROSS = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_SQ_X  = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_SQ_Y  = 2'd2;

    localparam int MAP_BITS = STEP_BITS + POS_BITS;
    localparam int SUM_BITS = MAP_BITS + 2;
    localparam int Q_BITS   = 2 * Z_BITS - FRAC_BITS + 1;

    localparam logic [Z_BITS-1:0] Z_MAX      = {1'b0, {(Z_BITS-1){1'b1}}};
    localparam logic [Z_BITS-1:0] Z_MIN      = {1'b1, {(Z_BITS-1){1'b0}}};
    localparam logic [Z_BITS-1:0] ESC_BOUND  = Z_BITS'(4) << FRAC_BITS;

    function automatic logic [C_BITS-1:0] sat_c(input logic [SUM_BITS-1:0] v);
        logic [SUM_BITS-C_BITS:0] top;
        top = v[SUM_BITS-1:C_BITS-1];
        if (&top || ~|top) begin
            sat_c = v[C_BITS-1:0];
        end else if (v[SUM_BITS-1]) begin
            sat_c = {1'b1, {(C_BITS-1){1'b0}}};
        end else begin
            sat_c = {1'b0, {(C_BITS-1){1'b1}}};
        end
    endfunction

    function automatic logic [Z_BITS-1:0] sat_z(input logic [Z_BITS:0] v);
        if (v[Z_BITS] == v[Z_BITS-1]) begin
            sat_z = v[Z_BITS-1:0];
        end else if (v[Z_BITS]) begin
            sat_z = Z_MIN;
        end else begin
            sat_z = Z_MAX;
        end
    endfunction

    logic [2:0]            r_state, n_state;
    logic [MAP_BITS-1:0]   r_mapx, n_mapx;
    logic [MAP_BITS-1:0]   r_mapy, n_mapy;
    logic [C_BITS-1:0]     r_cx, n_cx;
    logic [C_BITS-1:0]     r_cy, n_cy;
    logic [Z_BITS-1:0]     r_zx, n_zx;
    logic [Z_BITS-1:0]     r_zy, n_zy;
    logic [Z_BITS-1:0]     r_ax, n_ax;
    logic [Z_BITS-1:0]     r_ay, n_ay;
    logic                  r_negx, n_negx;
    logic                  r_negy, n_negy;
    logic [KIND_BITS-1:0]  r_issue, n_issue;
    logic [Z_BITS-1:0]     r_p, n_p;
    logic [Z_BITS-1:0]     r_sx, n_sx;
    logic [Z_BITS-1:0]     r_sy, n_sy;
    logic [Z_BITS-1:0]     r_diff, n_diff;
    logic                  r_sq_done, n_sq_done;
    logic [COUNT_BITS-1:0] r_iter, n_iter;

    logic [SUM_BITS-1:0]   w_cx_sum;
    logic [SUM_BITS-1:0]   w_cy_sum;
    logic [Z_BITS-1:0]     w_nx;
    logic [Z_BITS-1:0]     w_ny;
    logic [Z_BITS-1:0]     w_sqsum;
    logic                  w_escape;
    logic [COUNT_BITS-1:0] w_limit;
    t_cell_bus             w_issue;
    t_cell_bus             w_chain [0:NUM_CELLS];
    t_cell_bus             w_tail;
    logic [2*Z_BITS-1:0]   w_prod;
    logic [Q_BITS-1:0]     w_quo;
    logic                  w_over;
    logic [Z_BITS-1:0]     w_fix;

    assign w_cx_sum = {{(SUM_BITS-C_BITS){i_cfg.real_origin[C_BITS-1]}}, i_cfg.real_origin}
                    + {2'b00, r_mapx};
    assign w_cy_sum = {{(SUM_BITS-C_BITS){i_cfg.imag_origin[C_BITS-1]}}, i_cfg.imag_origin}
                    - {2'b00, r_mapy};

    assign w_nx = sat_z({r_diff[Z_BITS-1], r_diff}
                      + {{(Z_BITS+1-C_BITS){r_cx[C_BITS-1]}}, r_cx});
    assign w_ny = sat_z({r_p[Z_BITS-1], r_p}
                      + {{(Z_BITS+1-C_BITS){r_cy[C_BITS-1]}}, r_cy});

    // both squares are non-negative, so the sum cannot wrap
    assign w_sqsum  = r_sx + r_sy;
    assign w_escape = w_sqsum > ESC_BOUND;
    assign w_limit  = {1'b0, i_cfg.limit};

    // the three products of one iteration enter the chain on consecutive cycles
    always_comb begin
        w_issue = '0;
        if (r_state == ST_ISSUE) begin
            w_issue.valid = 1'b1;
            w_issue.kind  = r_issue;
            unique case (r_issue)
                KIND_CROSS: begin
                    w_issue.a   = r_ax;
                    w_issue.b   = r_ay;
                    w_issue.neg = r_negx ^ r_negy;
                end
                KIND_SQ_X: begin
                    w_issue.a = r_ax;
                    w_issue.b = r_ax;
                end
                KIND_SQ_Y: begin
                    w_issue.a = r_ay;
                    w_issue.b = r_ay;
                end
                default: begin
                    w_issue.valid = 1'b0;
                end
            endcase
        end
    end

    assign w_chain[0] = w_issue;

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        mbe_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bus   (w_chain[k]),
            .o_bus   (w_chain[k+1])
        );
    end

    assign w_tail = w_chain[NUM_CELLS];
    assign w_prod = {w_tail.hi, w_tail.lo};

    // cross product carries the factor of two as one less bit of shift
    always_comb begin
        if (w_tail.kind == KIND_CROSS) begin
            w_quo = w_prod[2*Z_BITS-1:FRAC_BITS-1];
        end else begin
            w_quo = {1'b0, w_prod[2*Z_BITS-1:FRAC_BITS]};
        end
        w_over = |w_quo[Q_BITS-1:Z_BITS-1];
        if (w_tail.neg) begin
            w_fix = w_over ? Z_MIN : Z_BITS'(0) - w_quo[Z_BITS-1:0];
        end else begin
            w_fix = w_over ? Z_MAX : w_quo[Z_BITS-1:0];
        end
    end

    always_comb begin
        n_state   = r_state;
        n_mapx    = r_mapx;
        n_mapy    = r_mapy;
        n_cx      = r_cx;
        n_cy      = r_cy;
        n_zx      = r_zx;
        n_zy      = r_zy;
        n_ax      = r_ax;
        n_ay      = r_ay;
        n_negx    = r_negx;
        n_negy    = r_negy;
        n_issue   = r_issue;
        n_p       = r_p;
        n_sx      = r_sx;
        n_sy      = r_sy;
        n_diff    = r_diff;
        n_sq_done = 1'b0;
        n_iter    = r_iter;

        unique case (r_state)
            ST_IDLE: begin
                if (i_ctrl.start) begin
                    n_state = ST_MAP;
                end
            end
            ST_MAP: begin
                n_mapx  = MAP_BITS'(i_column) * MAP_BITS'(i_cfg.pixel_step);
                n_mapy  = MAP_BITS'(i_row) * MAP_BITS'(i_cfg.pixel_step);
                n_state = ST_SAT;
            end
            ST_SAT: begin
                n_cx    = sat_c(w_cx_sum);
                n_cy    = sat_c(w_cy_sum);
                n_p     = '0;
                n_diff  = '0;
                n_iter  = COUNT_BITS'(1);
                n_state = (i_cfg.limit == '0) ? ST_DONE : ST_ADD;
            end
            ST_ADD: begin
                n_zx    = w_nx;
                n_zy    = w_ny;
                n_state = ST_MAG;
            end
            ST_MAG: begin
                n_ax    = r_zx[Z_BITS-1] ? Z_BITS'(0) - r_zx : r_zx;
                n_ay    = r_zy[Z_BITS-1] ? Z_BITS'(0) - r_zy : r_zy;
                n_negx  = r_zx[Z_BITS-1];
                n_negy  = r_zy[Z_BITS-1];
                n_issue = KIND_CROSS;
                n_state = ST_ISSUE;
            end
            ST_ISSUE: begin
                unique case (r_issue)
                    KIND_CROSS: n_issue = KIND_SQ_X;
                    KIND_SQ_X:  n_issue = KIND_SQ_Y;
                    default:    n_state = ST_WAIT;
                endcase
            end
            ST_WAIT: begin
                if (r_sq_done) begin
                    n_diff = r_sx - r_sy;
                    if (!w_escape) begin
                        n_iter = r_iter + COUNT_BITS'(1);
                    end
                    n_state = (w_escape || r_iter == w_limit) ? ST_DONE : ST_ADD;
                end
            end
            ST_DONE: begin
                if (i_ctrl.ack) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (w_tail.valid) begin
            unique case (w_tail.kind)
                KIND_CROSS: n_p = w_fix;
                KIND_SQ_X:  n_sx = w_fix;
                KIND_SQ_Y: begin
                    n_sy      = w_fix;
                    n_sq_done = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_mapx    <= n_mapx;
        r_mapy    <= n_mapy;
        r_cx      <= n_cx;
        r_cy      <= n_cy;
        r_zx      <= n_zx;
        r_zy      <= n_zy;
        r_ax      <= n_ax;
        r_ay      <= n_ay;
        r_negx    <= n_negx;
        r_negy    <= n_negy;
        r_p       <= n_p;
        r_sx      <= n_sx;
        r_sy      <= n_sy;
        r_diff    <= n_diff;
        r_iter    <= n_iter;
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_issue   <= KIND_CROSS;
            r_sq_done <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_issue   <= n_issue;
            r_sq_done <= n_sq_done;
        end
    end

    assign o_status.done  = (r_state == ST_DONE);
    assign o_status.count = r_iter;

    a_sq_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sq_done |-> r_state == ST_WAIT)
        else $error("square result arrived outside the wait state");

    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.start |-> r_state == ST_IDLE)
        else $error("pixel started while the iterator is busy");

    a_ack_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.ack |-> r_state == ST_DONE)
        else $error("result taken before the iteration finished");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DONE |-> r_iter != '0 && r_iter <= w_limit + COUNT_BITS'(1))
        else $error("final count outside one to limit plus one");

    a_wait_after_last_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WAIT && $past(r_state) == ST_ISSUE) |-> $past(r_issue) == KIND_SQ_Y)
        else $error("wait entered before all three products were issued");

endmodule

// ===== hw/rtl/mbe_color.sv =====
`timescale 1ns / 1ps
// color picker and ping-pong color level
module mbe_color (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_commit,
    input  logic                            i_row_end,
    input  logic [mbe_pkg::COUNT_BITS-1:0]  i_count,
    input  logic [mbe_pkg::LIMIT_BITS-1:0]  i_limit,
    output logic [mbe_pkg::COLOR_BITS-1:0]  o_color
);
    import mbe_pkg::*;

    localparam logic [COLOR_BITS-1:0] COLOR_DARK_GRAY = 24'h232323;
    localparam logic [COLOR_BITS-1:0] COLOR_WHITE     = 24'hFFFFFF;

    // {falling, level} after one step
    function automatic logic [COLOR_BITS:0] level_step(input logic [COLOR_BITS:0] s);
        logic                  fall;
        logic [COLOR_BITS-1:0] lvl;
        lvl  = s[COLOR_BITS-1:0];
        fall = s[COLOR_BITS];
        if (&lvl) begin
            fall = 1'b1;
        end else if (~|lvl) begin
            fall = 1'b0;
        end
        if (fall) begin
            lvl = lvl - COLOR_BITS'(1);
        end else begin
            lvl = lvl + COLOR_BITS'(1);
        end
        level_step = {fall, lvl};
    endfunction

    logic [COLOR_BITS-1:0] r_level, n_level;
    logic                  r_falling, n_falling;
    logic [COUNT_BITS-1:0] w_limit;
    logic [COLOR_BITS:0]   w_once;
    logic [COLOR_BITS:0]   w_twice;

    assign w_limit = {1'b0, i_limit};
    assign w_once  = level_step({r_falling, r_level});
    assign w_twice = level_step(w_once);

    always_comb begin
        if (i_count == w_limit + COUNT_BITS'(1)) begin
            o_color = COLOR_DARK_GRAY;
        end else if (i_count == w_limit) begin
            o_color = COLOR_WHITE;
        end else if (i_count == COUNT_BITS'(2) || i_count == COUNT_BITS'(4)) begin
            o_color = COLOR_DARK_GRAY;
        end else if (!i_count[0]) begin
            o_color = r_level;
        end else begin
            o_color = COLOR_DARK_GRAY;
        end
    end

    always_comb begin
        {n_falling, n_level} = {r_falling, r_level};
        if (i_commit) begin
            {n_falling, n_level} = i_row_end ? w_twice : w_once;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level   <= '0;
            r_falling <= 1'b0;
        end else begin
            r_level   <= n_level;
            r_falling <= n_falling;
        end
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the escape-time pixel core: driver, monitor and pixel predictor
module tb_top;
    import mbe_pkg::*;

    localparam int POS_TOP       = (1 << POS_BITS) - 1;
    localparam int CFG_LAST_IDX  = (1 << CFG_IDX_BITS) - 1;
    localparam int RANDOM_ITEMS  = 1850;
    localparam int SETTLE_CYCLES = 32;
    localparam int MAX_REPORTS   = 10;

    localparam logic [COLOR_BITS-1:0] DARK_GRAY = 24'h232323;
    localparam logic [COLOR_BITS-1:0] WHITE     = 24'hFFFFFF;
    localparam logic [COLOR_BITS-1:0] LEVEL_TOP = '1;

    localparam logic signed [Z_BITS-1:0] Z_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [Z_BITS-1:0] Z_MIN   = 64'sh8000_0000_0000_0000;
    localparam logic signed [Z_BITS-1:0] C48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [Z_BITS-1:0] C48_MIN = 64'shFFFF_8000_0000_0000;
    localparam logic [Z_BITS:0]          ESCAPE_BOUND = 65'd4 << FRAC_BITS;
    localparam logic signed [Z_BITS-1:0] ONE = 64'sd1 <<< FRAC_BITS;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic       in_valid = 1'b0;
    logic       in_stall;
    t_pixel_in  in_data = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_pixel_out out_data;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    int send_idle_pct = 14;
    int recv_stall_pct = 84;
    int bad_words = 0;

    t_pixel_in  pending_pixels[$];
    t_pixel_out expected_pixels[$];

    // predictor copy of the view registers and the ping-pong shade
    t_view_cfg view = '{limit: RST_LIMIT, real_origin: RST_REAL, imag_origin: RST_IMAG,
                        pixel_step: RST_STEP};
    logic [COLOR_BITS-1:0] shade_level = '0;
    logic                  shade_falling = 1'b0;

    logic [C_BITS-1:0]    c_extremes [3] = '{48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 48'h0};
    logic [STEP_BITS-1:0] step_extremes [3] = '{47'h0, 47'h1, 47'h7FFF_FFFF_FFFF};

    mandelbrot_escape_time_pixel_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial forever #1 clk = ~clk;

    function automatic logic signed [Z_BITS-1:0] sat_add(input logic signed [Z_BITS-1:0] a,
                                                        input logic signed [Z_BITS-1:0] b);
        logic signed [Z_BITS:0] s;
        s = (Z_BITS+1)'(a) + (Z_BITS+1)'(b);
        if (s > Z_MAX) return Z_MAX;
        if (s < Z_MIN) return Z_MIN;
        return s[Z_BITS-1:0];
    endfunction

    function automatic logic signed [Z_BITS-1:0] clamp48(input logic signed [Z_BITS-1:0] v);
        if (v > C48_MAX) return C48_MAX;
        if (v < C48_MIN) return C48_MIN;
        return v;
    endfunction

    // (a*b) >> sh on magnitudes, truncated toward zero, saturated to 64 bits
    function automatic logic signed [Z_BITS-1:0] scaled_product(
        input logic signed [Z_BITS-1:0] a,
        input logic signed [Z_BITS-1:0] b,
        input int sh
    );
        logic [Z_BITS-1:0]   ma, mb;
        logic [2*Z_BITS-1:0] q;
        ma = a[Z_BITS-1] ? ~a + 64'd1 : a;
        mb = b[Z_BITS-1] ? ~b + 64'd1 : b;
        q = ({64'd0, ma} * {64'd0, mb}) >> sh;
        if (a[Z_BITS-1] != b[Z_BITS-1]) begin
            if (q >= 128'h8000_0000_0000_0000) return Z_MIN;
            return ~q[Z_BITS-1:0] + 64'd1;
        end
        if (q > 128'h7FFF_FFFF_FFFF_FFFF) return Z_MAX;
        return q[Z_BITS-1:0];
    endfunction

    function automatic void shade_step();
        if (shade_level == LEVEL_TOP) shade_falling = 1'b1;
        else if (shade_level == '0) shade_falling = 1'b0;
        shade_level = shade_falling ? shade_level - COLOR_BITS'(1)
                                    : shade_level + COLOR_BITS'(1);
    endfunction

    function automatic t_pixel_out color_pixel(input t_pixel_in px);
        logic signed [Z_BITS-1:0] re_base, im_base, cx, cy, zx, zy, sx, sy, nx, ny;
        logic [Z_BITS-1:0] offs;
        int unsigned lim, count;
        t_pixel_out res;
        re_base = Z_BITS'(signed'(view.real_origin));
        im_base = Z_BITS'(signed'(view.imag_origin));
        offs = 64'(px.column) * 64'(view.pixel_step);
        cx = clamp48(re_base + offs);
        offs = 64'(px.row) * 64'(view.pixel_step);
        cy = clamp48(im_base - offs);
        lim = 32'(view.limit);
        count = 1;
        zx = '0; zy = '0; sx = '0; sy = '0;
        while (count <= lim) begin
            nx = sat_add(sx - sy, cx);
            ny = sat_add(scaled_product(zx, zy, FRAC_BITS - 1), cy);
            zx = nx;
            zy = ny;
            sx = scaled_product(zx, zx, FRAC_BITS);
            sy = scaled_product(zy, zy, FRAC_BITS);
            if ({1'b0, sx} + {1'b0, sy} > ESCAPE_BOUND) break;
            count++;
        end
        res.out_column = px.column;
        res.out_row = px.row;
        res.iteration_count = COUNT_BITS'(count);
        if (count == lim + 1) res.pixel_color = DARK_GRAY;
        else if (count == lim) res.pixel_color = WHITE;
        else if (count == 2 || count == 4) res.pixel_color = DARK_GRAY;
        else if (!count[0]) res.pixel_color = shade_level;
        else res.pixel_color = DARK_GRAY;
        shade_step();
        if (px.row_end) shade_step();
        return res;
    endfunction

    function automatic t_pixel_in pix(input int unsigned c, input int unsigned r,
                                      input int unsigned e);
        t_pixel_in p;
        p.column = c[POS_BITS-1:0];
        p.row = r[POS_BITS-1:0];
        p.row_end = e[0];
        return p;
    endfunction

    // pixel driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) expected_pixels.push_back(color_pixel(in_data));
            if (!in_valid || !in_stall) begin
                if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_data <= pending_pixels.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk) begin : check_results
        t_pixel_out want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_pixels.size() == 0) begin
                    bad_words++;
                    if (bad_words <= MAX_REPORTS)
                        $display("unexpected word (%0d,%0d) color %h count %0d",
                                 out_data.out_column, out_data.out_row, out_data.pixel_color,
                                 out_data.iteration_count);
                end else begin
                    want = expected_pixels.pop_front();
                    if (out_data.out_column !== want.out_column ||
                        out_data.out_row !== want.out_row ||
                        out_data.pixel_color !== want.pixel_color ||
                        out_data.iteration_count !== want.iteration_count) begin
                        bad_words++;
                        if (bad_words <= MAX_REPORTS)
                            $display("expected (%0d,%0d) %h/%0d got (%0d,%0d) %h/%0d",
                                     want.out_column, want.out_row, want.pixel_color,
                                     want.iteration_count, out_data.out_column, out_data.out_row,
                                     out_data.pixel_color, out_data.iteration_count);
                    end
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            CFG_LIMIT: view.limit = data[LIMIT_BITS-1:0];
            CFG_REAL:  view.real_origin = data;
            CFG_IMAG:  view.imag_origin = data;
            CFG_STEP:  view.pixel_step = data[STEP_BITS-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic set_view(input int unsigned lim, input logic [C_BITS-1:0] re0,
                            input logic [C_BITS-1:0] im0, input logic [STEP_BITS-1:0] step);
        write_reg(CFG_LIMIT, CFG_DATA_BITS'(lim));
        write_reg(CFG_REAL, re0);
        write_reg(CFG_IMAG, im0);
        write_reg(CFG_STEP, CFG_DATA_BITS'(step));
    endtask

    // sender holds off until every word in flight has come back
    task automatic wait_drained();
        @(posedge clk);
        while (pending_pixels.size() != 0 || in_valid || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin : stimulus
        int unsigned lim, style, n, k, run, c0, r, mode, random_sent;
        logic [Z_BITS-1:0] step, re0, im0;
        logic signed [Z_BITS-1:0] ctr_re, ctr_im;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset view: -2..+2 on both axes
        @(negedge clk);
        pending_pixels.push_back(pix(0, 0, 0));
        pending_pixels.push_back(pix(POS_TOP, POS_TOP, 1));
        pending_pixels.push_back(pix(POS_TOP, 0, 0));
        pending_pixels.push_back(pix(0, POS_TOP, 1));
        pending_pixels.push_back(pix(512, 512, 0));
        pending_pixels.push_back(pix(0, 512, 0));
        pending_pixels.push_back(pix(256, 512, 1));
        pending_pixels.push_back(pix(768, 512, 0));
        pending_pixels.push_back(pix(640, 512, 0));
        pending_pixels.push_back(pix(560, 512, 0));
        pending_pixels.push_back(pix(579, 512, 1));
        pending_pixels.push_back(pix(512, 128, 0));
        pending_pixels.push_back(pix('h2AA, 'h155, 1));
        pending_pixels.push_back(pix('h155, 'h2AA, 0));
        wait_drained();

        // zero limit: no iteration runs
        write_reg(CFG_LIMIT, '0);
        @(negedge clk);
        pending_pixels.push_back(pix(0, 0, 1));
        pending_pixels.push_back(pix(512, 512, 0));
        pending_pixels.push_back(pix(POS_TOP, POS_TOP, 0));
        wait_drained();

        // zero step, then writes to unused indexes that must change nothing
        set_view(1, RST_REAL, RST_IMAG, '0);
        write_reg(CFG_IDX_BITS'(CFG_STEP + 1), CFG_DATA_BITS'({$urandom, $urandom}));
        write_reg(CFG_IDX_BITS'(CFG_LAST_IDX), CFG_DATA_BITS'({$urandom, $urandom}));
        @(negedge clk);
        pending_pixels.push_back(pix(0, 0, 0));
        pending_pixels.push_back(pix(POS_TOP, 77, 1));
        wait_drained();

        set_view(2, '0, '0, '0);
        @(negedge clk);
        pending_pixels.push_back(pix(3, 900, 0));
        pending_pixels.push_back(pix(900, 3, 1));
        wait_drained();

        // deepest limit at the origin never escapes
        set_view(255, '0, '0, '0);
        @(negedge clk);
        pending_pixels.push_back(pix(100, 200, 0));
        wait_drained();

        // c range extremes with saturation
        set_view(255, c_extremes[0], c_extremes[1], step_extremes[2]);
        @(negedge clk);
        pending_pixels.push_back(pix(0, 0, 0));
        pending_pixels.push_back(pix(POS_TOP, POS_TOP, 1));
        pending_pixels.push_back(pix(1, POS_TOP, 0));
        wait_drained();

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            mode = random_sent * 3 / RANDOM_ITEMS;
            style = $urandom_range(0, 9);
            lim = ($urandom_range(0, 7) == 0) ? 255 : $urandom_range(1, 24);
            if (style <= 6) begin
                // window somewhere over the set, 1/256 down to 2^-20 per pixel
                step = ({$urandom, $urandom} >> $urandom_range(28, 40)) | 64'd1;
                ctr_re = 64'($urandom_range(0, 2500)) * (ONE / 1000) - 2 * ONE;
                ctr_im = 64'($urandom_range(0, 2500)) * (ONE / 1000) - ONE * 5 / 4;
                re0 = ctr_re - 512 * step;
                im0 = ctr_im + 512 * step;
            end else if (style <= 8) begin
                re0 = {$urandom, $urandom};
                im0 = {$urandom, $urandom};
                step = {$urandom, $urandom};
            end else begin
                re0 = 64'(c_extremes[$urandom_range(0, 2)]);
                im0 = 64'(c_extremes[$urandom_range(0, 2)]);
                step = 64'(step_extremes[$urandom_range(0, 2)]);
            end
            set_view(lim, re0[C_BITS-1:0], im0[C_BITS-1:0], step[STEP_BITS-1:0]);

            @(negedge clk);
            case (mode)
                0: begin
                    send_idle_pct = 14;
                    recv_stall_pct = 84;
                end
                1: begin
                    send_idle_pct = 84;
                    recv_stall_pct = 14;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
            endcase
            n = (lim == 255) ? 30 : $urandom_range(60, 140);
            k = 0;
            while (k < n) begin
                if (style <= 6 && $urandom_range(0, 9) != 0) begin
                    // a run of neighbours along one row, closed by a row end
                    run = $urandom_range(2, 16);
                    c0 = $urandom_range(0, POS_TOP + 1 - run);
                    r = $urandom_range(0, POS_TOP);
                    for (int j = 0; j < run; j++)
                        pending_pixels.push_back(pix(c0 + j, r, (j == run - 1) ? 1 : 0));
                    k += run;
                end else begin
                    pending_pixels.push_back(pix($urandom_range(0, POS_TOP),
                                                 $urandom_range(0, POS_TOP),
                                                 $urandom_range(0, 1)));
                    k++;
                end
            end
            random_sent += k;
            wait_drained();
        end

        if (bad_words == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/mbe_pkg.sv
hw/rtl/mbe_cell.sv
hw/rtl/mbe_iter.sv
hw/rtl/mbe_color.sv
hw/rtl/mandelbrot_escape_time_pixel_core.sv
verif/tb_top.sv
